/* hw/rtl/infix_to_postfix_converter_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter
// All macros sample on the rising edge of clk and are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH

// Condition holds at every clock edge out of reset
`define IFP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle
`define IFP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle
`define IFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ifp_pkg.sv */
// ----------------------------------------------------------------------------
// ifp_pkg
// Token codes, result codes, sequencer states and operator precedence for
// the infix to postfix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ifp_pkg;

  // Input token opcodes
  localparam logic [2:0] OPC_OPERAND = 3'd0;
  localparam logic [2:0] OPC_BINOP   = 3'd1;
  localparam logic [2:0] OPC_LPAREN  = 3'd2;
  localparam logic [2:0] OPC_RPAREN  = 3'd3;
  localparam logic [2:0] OPC_END     = 3'd4;

  // Operator codes with special meaning
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_MOD   = 3'd4;
  localparam logic [2:0] OP_POWER = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_OPERAND  = 2'd0;
  localparam logic [1:0] KIND_OPERATOR = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_RPAREN   = 2'd1;
  localparam logic [1:0] ERR_LPAREN   = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,   // waiting for a token
    ST_TOP,    // top-of-stack entry on the RAM read port
    ST_FINAL,  // popping done, apply the token itself
    ST_LAST    // deliver the closing result after a held operator
  } state_t;

  // Operator precedence; unknown codes bind weakest
  function automatic logic [2:0] prec(input logic [2:0] op);
    logic [2:0] p;
    if (op == OP_POWER) begin
      p = 3'd4;
    end else if (op >= OP_MUL && op <= OP_MOD) begin
      p = 3'd3;
    end else if (op < OP_MUL) begin
      p = 3'd2;
    end else begin
      p = 3'd1;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ifp_token_if.sv */
// ----------------------------------------------------------------------------
// ifp_token_if
// Valid/ready channel carrying one infix token per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifp_token_if #(
  parameter int TAG_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [2:0]          opcode;
  logic [2:0]          operator_code;
  logic [TAG_BITS-1:0] token_tag;

  modport source (output valid, output opcode, output operator_code,
                  output token_tag, input ready);
  modport sink   (input valid, input opcode, input operator_code,
                  input token_tag, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ifp_result_if.sv */
// ----------------------------------------------------------------------------
// ifp_result_if
// Valid/ready channel carrying one postfix result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifp_result_if #(
  parameter int TAG_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [1:0]          out_kind;
  logic [2:0]          out_operator;
  logic [TAG_BITS-1:0] out_tag;
  logic [1:0]          error_code;
  logic                out_last;

  modport source (output valid, output out_kind, output out_operator,
                  output out_tag, output error_code, output out_last,
                  input ready);
  modport sink   (input valid, input out_kind, input out_operator,
                  input out_tag, input error_code, input out_last,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/ifp_stack_ram.sv */
// ----------------------------------------------------------------------------
// ifp_stack_ram
// Single-clock RAM for the operator stack: one write port, one read port,
// registered read data (held when no read is issued).
// ----------------------------------------------------------------------------
`default_nettype none

module ifp_stack_ram #(
  parameter  int DEPTH = 32,
  parameter  int WIDTH = 20,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/infix_to_postfix_converter_unit.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard converter: infix tokens in, postfix results out, with the operator
// stack kept in a synchronous RAM and walked one entry per cycle unless output stalls.
// ----------------------------------------------------------------------------
// Flow: a new token is taken only in ST_IDLE, once the previous token is done;
//   popped operators then follow one per cycle while the output accepts them.
// Reset: synchronous rst clears the sequencer, stack count, error flag and
//   output valid; stack RAM contents are not cleared (no clearing pass).
`default_nettype none

module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = 32,
  parameter int TAG_BITS    = 16
) (
  input wire logic      clk,
  input wire logic      rst,
  ifp_token_if.sink     token,
  ifp_result_if.source  result
);

  import ifp_pkg::*;

  `include "infix_to_postfix_converter_unit_defines.svh"

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = TAG_BITS + 4;  // lparen flag, operator, tag

  // Sequencer and stack state
  state_t              state, state_next;
  logic [CW-1:0]       count, count_next;
  logic                error_seen, error_seen_next;
  logic                stop_lp, stop_lp_next;

  // Latched token
  logic [2:0]          tok_opcode, tok_opc;
  logic [TAG_BITS-1:0] tok_tag;

  // Popped operator waiting for its last flag
  logic                hold_valid, hold_valid_next;
  logic [2:0]          hold_op;
  logic [TAG_BITS-1:0] hold_tag;
  logic                hold_load;

  // Closing result kept for ST_LAST
  logic [1:0]          fin_kind, fin_err;
  logic [TAG_BITS-1:0] fin_tag;
  logic                fin_load;

  // Output register
  logic                out_valid;
  logic [1:0]          out_kind, out_err;
  logic [2:0]          out_opr;
  logic [TAG_BITS-1:0] out_tag;
  logic                out_last;
  logic                out_load;
  logic [1:0]          ld_kind, ld_err;
  logic [2:0]          ld_opr;
  logic [TAG_BITS-1:0] ld_tag;
  logic                ld_last;
  logic                out_free;

  // RAM ports
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [EW-1:0]       ram_wdata, ram_rdata;

  // Decoded top-of-stack entry
  logic                e_lp;
  logic [2:0]          e_op;
  logic [TAG_BITS-1:0] e_tag;
  logic [2:0]          e_prec, t_prec;
  logic                pop_it;

  // Final action of the token
  logic                f_has, f_push, f_pop, f_clear, f_err_set;
  logic [1:0]          f_kind, f_err;
  logic [TAG_BITS-1:0] f_tag;
  logic                stack_full;

  logic                tok_acc;
  logic [CW-1:0]       cnt_m1, cnt_m2;

  ifp_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (EW)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign token.ready         = (state == ST_IDLE) && !rst;
  assign tok_acc             = token.valid && token.ready;

  assign result.valid        = out_valid;
  assign result.out_kind     = out_kind;
  assign result.out_operator = out_opr;
  assign result.out_tag      = out_tag;
  assign result.error_code   = out_err;
  assign result.out_last     = out_last;

  assign out_free   = !out_valid || result.ready;
  assign stack_full = (count == CW'(STACK_DEPTH));
  assign cnt_m1     = count - CW'(1);
  assign cnt_m2     = count - CW'(2);

  assign e_lp   = ram_rdata[EW-1];
  assign e_op   = ram_rdata[TAG_BITS+2:TAG_BITS];
  assign e_tag  = ram_rdata[TAG_BITS-1:0];
  assign e_prec = prec(e_op);
  assign t_prec = prec(tok_opc);

  // Pop rule: end marker and right paren pop any operator, a binary operator
  // pops higher precedence, or equal precedence unless it is power
  always_comb begin
    if (e_lp) begin
      pop_it = 1'b0;
    end else if (tok_opcode == OPC_BINOP) begin
      pop_it = (e_prec > t_prec) || ((e_prec == t_prec) && (tok_opc != OP_POWER));
    end else begin
      pop_it = 1'b1;
    end
  end

  // What the token does once popping has stopped
  always_comb begin
    f_has     = 1'b0;
    f_push    = 1'b0;
    f_pop     = 1'b0;
    f_clear   = 1'b0;
    f_err_set = 1'b0;
    f_kind    = KIND_END;
    f_err     = ERR_NONE;
    f_tag     = '0;
    unique case (tok_opcode)
      OPC_OPERAND: begin
        f_has  = 1'b1;
        f_kind = KIND_OPERAND;
        f_tag  = tok_tag;
      end
      OPC_BINOP, OPC_LPAREN: begin
        if (stack_full) begin
          f_has     = 1'b1;
          f_kind    = KIND_ERROR;
          f_err     = ERR_OVERFLOW;
          f_err_set = 1'b1;
        end else begin
          f_push = 1'b1;
        end
      end
      OPC_RPAREN: begin
        if (stop_lp) begin
          f_pop = 1'b1;
        end else begin
          f_has     = 1'b1;
          f_kind    = KIND_ERROR;
          f_err     = ERR_RPAREN;
          f_err_set = 1'b1;
        end
      end
      OPC_END: begin
        f_has   = 1'b1;
        f_clear = 1'b1;
        if (stop_lp && !error_seen) begin
          f_kind = KIND_ERROR;
          f_err  = ERR_LPAREN;
        end
      end
      default: begin
      end
    endcase
  end

  // Push data: left paren stores flag and tag, operator stores code and tag
  assign ram_wdata = {(tok_opcode == OPC_LPAREN),
                      (tok_opcode == OPC_LPAREN) ? 3'd0 : tok_opc, tok_tag};
  assign ram_waddr = count[AW-1:0];

  // Sequencer next state. Reads happen in ST_IDLE/ST_TOP and writes only in
  // ST_FINAL, so a read never overlaps a write to the same entry.
  always_comb begin
    state_next      = state;
    count_next      = count;
    error_seen_next = error_seen;
    stop_lp_next    = stop_lp;
    hold_valid_next = hold_valid;
    hold_load       = 1'b0;
    fin_load        = 1'b0;
    out_load        = 1'b0;
    ld_kind         = KIND_OPERATOR;
    ld_opr          = hold_op;
    ld_tag          = hold_tag;
    ld_err          = ERR_NONE;
    ld_last         = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = cnt_m1[AW-1:0];

    unique case (state)
      ST_IDLE: begin
        stop_lp_next = 1'b0;
        if (tok_acc) begin
          if (token.opcode > OPC_END) begin
            state_next = ST_IDLE;
          end else if (error_seen && token.opcode != OPC_END) begin
            state_next = ST_IDLE;
          end else if (!error_seen && count != '0 &&
                       (token.opcode == OPC_BINOP || token.opcode == OPC_RPAREN ||
                        token.opcode == OPC_END)) begin
            ram_re     = 1'b1;
            state_next = ST_TOP;
          end else begin
            state_next = ST_FINAL;
          end
        end
      end

      ST_TOP: begin
        if (!pop_it) begin
          stop_lp_next = e_lp;
          state_next   = ST_FINAL;
        end else if (!hold_valid || out_free) begin
          // previous pop is known not to be last
          if (hold_valid) begin
            out_load = 1'b1;
          end
          hold_load       = 1'b1;
          hold_valid_next = 1'b1;
          count_next      = cnt_m1;
          if (count != CW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = cnt_m2[AW-1:0];
          end else begin
            state_next = ST_FINAL;
          end
        end
      end

      ST_FINAL: begin
        if (!(hold_valid || f_has) || out_free) begin
          // stack and flag updates
          if (f_push) begin
            ram_we     = 1'b1;
            count_next = count + CW'(1);
          end
          if (f_pop) begin
            count_next = cnt_m1;
          end
          if (f_err_set) begin
            error_seen_next = 1'b1;
          end
          if (f_clear) begin
            count_next      = '0;
            error_seen_next = 1'b0;
          end
          // results
          if (hold_valid) begin
            out_load        = 1'b1;
            ld_last         = !f_has;
            hold_valid_next = 1'b0;
            if (f_has) begin
              fin_load   = 1'b1;
              state_next = ST_LAST;
            end else begin
              state_next = ST_IDLE;
            end
          end else begin
            if (f_has) begin
              out_load = 1'b1;
              ld_kind  = f_kind;
              ld_opr   = 3'd0;
              ld_tag   = f_tag;
              ld_err   = f_err;
              ld_last  = 1'b1;
            end
            state_next = ST_IDLE;
          end
        end
      end

      ST_LAST: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_kind    = fin_kind;
          ld_opr     = 3'd0;
          ld_tag     = fin_tag;
          ld_err     = fin_err;
          ld_last    = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      error_seen <= 1'b0;
      stop_lp    <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      error_seen <= error_seen_next;
      stop_lp    <= stop_lp_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_load || (out_valid && !result.ready);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (tok_acc) begin
      tok_opcode <= token.opcode;
      tok_opc    <= token.operator_code;
      tok_tag    <= token.token_tag;
    end
    if (hold_load) begin
      hold_op  <= e_op;
      hold_tag <= e_tag;
    end
    if (fin_load) begin
      fin_kind <= f_kind;
      fin_err  <= f_err;
      fin_tag  <= f_tag;
    end
    if (out_load) begin
      out_kind <= ld_kind;
      out_opr  <= ld_opr;
      out_tag  <= ld_tag;
      out_err  <= ld_err;
      out_last <= ld_last;
    end
  end

  // Checks
  `IFP_ASSERT_ALWAYS(a_count_bound, count <= CW'(STACK_DEPTH), "stack count above depth")
  `IFP_ASSERT_IMPLY(a_top_nonempty, state == ST_TOP, count != '0, "stack walk on empty stack")
  `IFP_ASSERT_IMPLY(a_idle_no_hold, state == ST_IDLE, !hold_valid, "held operator left in idle")
  `IFP_ASSERT_IMPLY(a_err_code, out_valid && out_kind == KIND_ERROR, out_err != ERR_NONE,
                    "error result without error code")
  `IFP_ASSERT_NEXT(a_last_path, state == ST_LAST && out_free, state == ST_IDLE,
                   "closing result did not finish the token")

endmodule

`default_nettype wire

/* tb/infix_to_postfix_converter_unit_test.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit_test
// Drives infix tokens into the converter and checks every postfix beat
// against a shunting-yard predictor kept in the bench. A short scripted run
// covers extremes, every operator, associativity, error codes and overflow.
// Random expressions, mostly well formed with noise mixed in, follow. Both
// sides idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter_unit_test;
  import ifp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 32;
  localparam int TAGW         = 16;
  localparam int RANDOM_TOKENS = 380;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;

  // Opcodes the block ignores
  localparam logic [2:0] OPC_SPARE5 = 3'd5;
  localparam logic [2:0] OPC_SPARE6 = 3'd6;
  localparam logic [2:0] OPC_SPARE7 = 3'd7;

  typedef enum logic [2:0] {
    OPER_ADD, OPER_SUB, OPER_MUL, OPER_DIV, OPER_MOD, OPER_POW, OPER_RSV6, OPER_RSV7
  } oper_t;

  typedef struct packed {
    logic [2:0]      opcode;
    logic [2:0]      oper;
    logic [TAGW-1:0] tag;
  } token_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [2:0]      oper;
    logic [TAGW-1:0] tag;
    logic [1:0]      err;
    logic            last;
  } postfix_beat_t;

  // One scripted row; a typed row carries its single expected beat
  typedef struct packed {
    token_t     tok;
    logic [5:0] reps;
    logic       typed;
    logic [1:0] kind;
    logic [1:0] err;
  } script_row_t;

  logic clk;
  logic rst;

  ifp_token_if  #(.TAG_BITS(TAGW)) tok_if ();
  ifp_result_if #(.TAG_BITS(TAGW)) res_if ();

  infix_to_postfix_converter_unit #(
    .STACK_DEPTH(DEPTH),
    .TAG_BITS   (TAGW)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .token (tok_if),
    .result(res_if)
  );

  // Predictor state
  logic [2:0]      opstk_oper [DEPTH];
  logic [TAGW-1:0] opstk_tag  [DEPTH];
  logic            opstk_lp   [DEPTH];
  int unsigned     opstk_fill;
  bit              err_latched;

  postfix_beat_t postfix_due[$];
  token_t        expr_tokens[$];
  script_row_t   script[$];

  int  fail_count;
  int  tokens_sent;
  int  live_tokens;
  int  beats_checked;
  int  error_beats;
  int  expr_count;
  bit  steady;
  bit  hold_req;
  bit  hold_done;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [2:0] bind_strength(input logic [2:0] oper);
    case (oper)
      OPER_POW:                    return 3'd4;
      OPER_MUL, OPER_DIV, OPER_MOD: return 3'd3;
      OPER_ADD, OPER_SUB:          return 3'd2;
      default:                     return 3'd1;
    endcase
  endfunction

  function automatic postfix_beat_t make_beat(input logic [1:0] kind, input logic [2:0] oper,
                                              input logic [TAGW-1:0] tag,
                                              input logic [1:0] err);
    postfix_beat_t b;
    b.kind = kind;
    b.oper = oper;
    b.tag  = tag;
    b.err  = err;
    b.last = 1'b0;
    return b;
  endfunction

  // Shunting-yard step: updates the stack model, returns the beats this token emits
  function automatic void convert_token(input token_t t, output postfix_beat_t beats[$]);
    logic [2:0] p;
    logic [2:0] tp;
    bit         stop;
    bit         found;
    beats = {};
    if (t.opcode > OPC_END) return;
    if (t.opcode == OPC_END) begin
      found = 1'b0;
      if (!err_latched) begin
        stop = 1'b0;
        while (opstk_fill > 0 && !stop) begin
          if (opstk_lp[opstk_fill-1]) begin
            stop  = 1'b1;
            found = 1'b1;
          end else begin
            beats.push_back(make_beat(KIND_OPERATOR, opstk_oper[opstk_fill-1],
                                      opstk_tag[opstk_fill-1], ERR_NONE));
            opstk_fill--;
          end
        end
      end
      if (found) beats.push_back(make_beat(KIND_ERROR, 3'd0, '0, ERR_LPAREN));
      else beats.push_back(make_beat(KIND_END, 3'd0, '0, ERR_NONE));
      opstk_fill  = 0;
      err_latched = 1'b0;
    end else if (!err_latched) begin
      case (t.opcode)
        OPC_OPERAND: begin
          beats.push_back(make_beat(KIND_OPERAND, 3'd0, t.tag, ERR_NONE));
        end
        OPC_BINOP: begin
          p    = bind_strength(t.oper);
          stop = 1'b0;
          while (opstk_fill > 0 && !stop) begin
            tp = bind_strength(opstk_oper[opstk_fill-1]);
            if (!opstk_lp[opstk_fill-1] &&
                (tp > p || (tp == p && t.oper != OPER_POW))) begin
              beats.push_back(make_beat(KIND_OPERATOR, opstk_oper[opstk_fill-1],
                                        opstk_tag[opstk_fill-1], ERR_NONE));
              opstk_fill--;
            end else begin
              stop = 1'b1;
            end
          end
          if (opstk_fill >= DEPTH) begin
            beats.push_back(make_beat(KIND_ERROR, 3'd0, '0, ERR_OVERFLOW));
            err_latched = 1'b1;
          end else begin
            opstk_oper[opstk_fill] = t.oper;
            opstk_tag[opstk_fill]  = t.tag;
            opstk_lp[opstk_fill]   = 1'b0;
            opstk_fill++;
          end
        end
        OPC_LPAREN: begin
          if (opstk_fill >= DEPTH) begin
            beats.push_back(make_beat(KIND_ERROR, 3'd0, '0, ERR_OVERFLOW));
            err_latched = 1'b1;
          end else begin
            opstk_oper[opstk_fill] = 3'd0;
            opstk_tag[opstk_fill]  = t.tag;
            opstk_lp[opstk_fill]   = 1'b1;
            opstk_fill++;
          end
        end
        default: begin
          // right paren: flush down to the matching left paren
          found = 1'b0;
          while (opstk_fill > 0 && !found) begin
            if (opstk_lp[opstk_fill-1]) begin
              found = 1'b1;
            end else begin
              beats.push_back(make_beat(KIND_OPERATOR, opstk_oper[opstk_fill-1],
                                        opstk_tag[opstk_fill-1], ERR_NONE));
              opstk_fill--;
            end
          end
          if (found) begin
            opstk_fill--;
          end else begin
            beats.push_back(make_beat(KIND_ERROR, 3'd0, '0, ERR_RPAREN));
            err_latched = 1'b1;
          end
        end
      endcase
    end
    if (beats.size() > 0) beats[beats.size()-1].last = 1'b1;
  endfunction

  // Offer one token, wait for its beat, then log what it should produce
  task automatic offer_token(input token_t t, input bit typed, input postfix_beat_t typed_beat);
    postfix_beat_t beats[$];
    bit            live;
    while (!steady && $urandom_range(99) < 31) begin
      tok_if.valid <= 1'b0;
      @(posedge clk);
    end
    tok_if.valid         <= 1'b1;
    tok_if.opcode        <= t.opcode;
    tok_if.operator_code <= t.oper;
    tok_if.token_tag     <= t.tag;
    @(posedge clk);
    while (!tok_if.ready) @(posedge clk);
    live = (t.opcode <= OPC_END) && (!err_latched || t.opcode == OPC_END);
    convert_token(t, beats);
    if (typed) postfix_due.push_back(typed_beat);
    else foreach (beats[i]) postfix_due.push_back(beats[i]);
    tokens_sent++;
    if (live) live_tokens++;
  endtask

  function automatic script_row_t script_line(input logic [2:0] opcode, input logic [2:0] oper,
                                              input logic [TAGW-1:0] tag, input int reps,
                                              input bit typed, input logic [1:0] kind,
                                              input logic [1:0] err);
    script_row_t r;
    r.tok.opcode = opcode;
    r.tok.oper   = oper;
    r.tok.tag    = tag;
    r.reps       = reps[5:0];
    r.typed      = typed;
    r.kind       = kind;
    r.err        = err;
    return r;
  endfunction

  function automatic void add_tok(input logic [2:0] opcode, input logic [2:0] oper);
    token_t t;
    t.opcode = opcode;
    t.oper   = oper;
    t.tag    = TAGW'($urandom);
    expr_tokens.push_back(t);
  endfunction

  function automatic logic [2:0] pick_oper();
    if ($urandom_range(9) == 0) return 3'($urandom_range(OPER_RSV6, OPER_RSV7));
    return 3'($urandom_range(OPER_ADD, OPER_POW));
  endfunction

  // Random well-formed expression, nesting up to the given level
  function automatic void grow_expr(input int level);
    int n;
    n = $urandom_range(0, 4);
    grow_term(level);
    repeat (n) begin
      add_tok(OPC_BINOP, pick_oper());
      grow_term(level);
    end
  endfunction

  function automatic void grow_term(input int level);
    if (level > 0 && $urandom_range(3) == 0) begin
      add_tok(OPC_LPAREN, 3'($urandom_range(0, 7)));
      grow_expr(level - 1);
      add_tok(OPC_RPAREN, 3'($urandom_range(0, 7)));
    end else begin
      add_tok(OPC_OPERAND, 3'($urandom_range(0, 7)));
    end
  endfunction

  // Result side: random stalls, one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        res_if.ready <= steady || ($urandom_range(99) >= 31);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    postfix_beat_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (postfix_due.size() == 0) begin
        $error("unexpected beat: kind %0d operator %0d tag %0h error %0d",
               res_if.out_kind, res_if.out_operator, res_if.out_tag, res_if.error_code);
        fail_count++;
      end else begin
        want = postfix_due.pop_front();
        beats_checked++;
        if (res_if.out_kind == KIND_ERROR) error_beats++;
        if (res_if.out_kind !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, res_if.out_kind);
          fail_count++;
        end
        if (res_if.out_operator !== want.oper) begin
          $error("out_operator: expected %0d, got %0d", want.oper, res_if.out_operator);
          fail_count++;
        end
        if (res_if.out_tag !== want.tag) begin
          $error("out_tag: expected %0h, got %0h", want.tag, res_if.out_tag);
          fail_count++;
        end
        if (res_if.error_code !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, res_if.error_code);
          fail_count++;
        end
        if (res_if.out_last !== want.last) begin
          $error("out_last: expected %0d, got %0d", want.last, res_if.out_last);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    script_row_t   row;
    postfix_beat_t typed_beat;
    token_t        t;
    int            k;
    int            pick;
    fail_count    = 0;
    tokens_sent   = 0;
    live_tokens   = 0;
    beats_checked = 0;
    error_beats   = 0;
    expr_count    = 0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    opstk_fill    = 0;
    err_latched   = 1'b0;
    rst                  <= 1'b1;
    tok_if.valid         <= 1'b0;
    tok_if.opcode        <= OPC_OPERAND;
    tok_if.operator_code <= OPER_ADD;
    tok_if.token_tag     <= '0;

    // Scripted run: extremes, each operator, associativity, every error code
    script.push_back(script_line(OPC_END,     OPER_ADD,  16'h0000, 1, 1, KIND_END, ERR_NONE));
    script.push_back(script_line(OPC_OPERAND, OPER_ADD,  16'h0000, 1, 1, KIND_OPERAND, ERR_NONE));
    script.push_back(script_line(OPC_OPERAND, OPER_RSV7, 16'hFFFF, 1, 1, KIND_OPERAND, ERR_NONE));
    script.push_back(script_line(OPC_BINOP,   OPER_ADD,  16'h0011, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_OPERAND, OPER_ADD,  16'h0012, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_BINOP,   OPER_MUL,  16'h0013, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_OPERAND, OPER_ADD,  16'h0014, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_BINOP,   OPER_SUB,  16'h0015, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_LPAREN,  OPER_ADD,  16'h0016, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_OPERAND, OPER_ADD,  16'h0017, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_BINOP,   OPER_POW,  16'h0018, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_OPERAND, OPER_ADD,  16'h0019, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_BINOP,   OPER_POW,  16'h001A, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_OPERAND, OPER_ADD,  16'h001B, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_BINOP,   OPER_DIV,  16'h001C, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_OPERAND, OPER_ADD,  16'h001D, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_BINOP,   OPER_MOD,  16'h001E, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_BINOP,   OPER_RSV6, 16'h001F, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_BINOP,   OPER_RSV7, 16'h0020, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_OPERAND, OPER_ADD,  16'h0021, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_RPAREN,  OPER_ADD,  16'h0022, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_END,     OPER_ADD,  16'h0023, 1, 0, '0, ERR_NONE));
    // stray right paren, then tokens are dropped until the end marker
    script.push_back(script_line(OPC_RPAREN,  OPER_ADD,  16'h0024, 1, 1, KIND_ERROR, ERR_RPAREN));
    script.push_back(script_line(OPC_OPERAND, OPER_ADD,  16'hAAAA, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_END,     OPER_ADD,  16'h5555, 1, 1, KIND_END, ERR_NONE));
    // unused opcodes are ignored
    script.push_back(script_line(OPC_SPARE5,  OPER_POW,  16'h5555, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_SPARE6,  OPER_RSV6, 16'hAAAA, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_SPARE7,  OPER_RSV7, 16'hFFFF, 1, 0, '0, ERR_NONE));
    // open paren left at the end, with and without a pending operator
    script.push_back(script_line(OPC_LPAREN,  OPER_ADD,  16'h0030, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_BINOP,   OPER_ADD,  16'h0031, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_END,     OPER_ADD,  16'h0032, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_LPAREN,  OPER_ADD,  16'h0033, 1, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_END,     OPER_ADD,  16'h0034, 1, 1, KIND_ERROR, ERR_LPAREN));
    // fill the stack, then one push too many
    script.push_back(script_line(OPC_LPAREN,  OPER_ADD,  16'h0040, DEPTH, 0, '0, ERR_NONE));
    script.push_back(script_line(OPC_LPAREN,  OPER_ADD,  16'h0041, 1, 1, KIND_ERROR, ERR_OVERFLOW));
    script.push_back(script_line(OPC_END,     OPER_ADD,  16'h0042, 1, 1, KIND_END, ERR_NONE));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      row        = script[i];
      typed_beat = make_beat(row.kind, 3'd0, row.typed && row.kind == KIND_OPERAND ?
                             row.tok.tag : '0, row.err);
      typed_beat.last = 1'b1;
      for (k = 0; k < row.reps; k++) offer_token(row.tok, row.typed, typed_beat);
    end

    // Random expressions: mostly well formed, some deep nests and some noise
    typed_beat = '0;
    while (live_tokens < RANDOM_TOKENS) begin
      steady = (live_tokens >= 150 && live_tokens < 260);
      if (!hold_done && live_tokens >= 300) begin
        hold_req  <= 1'b1;
        hold_done  = 1'b1;
      end
      expr_tokens.delete();
      pick = $urandom_range(99);
      if (pick < 6) begin
        // deep nest, can run into overflow on either kind of push
        repeat ($urandom_range(14, 22)) begin
          add_tok(OPC_LPAREN, 3'($urandom_range(0, 7)));
          if ($urandom_range(1)) begin
            add_tok(OPC_OPERAND, 3'($urandom_range(0, 7)));
            add_tok(OPC_BINOP, pick_oper());
          end
        end
        add_tok(OPC_OPERAND, 3'($urandom_range(0, 7)));
        repeat ($urandom_range(0, 36)) add_tok(OPC_RPAREN, 3'($urandom_range(0, 7)));
      end else begin
        grow_expr(3);
      end
      if (pick >= 80) begin
        // noise: a random token dropped in, or a token taken out
        k = $urandom_range(0, expr_tokens.size() - 1);
        if ($urandom_range(1)) begin
          t.opcode = 3'($urandom_range(0, 7));
          t.oper   = 3'($urandom_range(0, 7));
          t.tag    = TAGW'($urandom);
          expr_tokens.insert(k, t);
        end else begin
          expr_tokens.delete(k);
        end
      end
      add_tok(OPC_END, 3'($urandom_range(0, 7)));
      foreach (expr_tokens[i]) offer_token(expr_tokens[i], 1'b0, typed_beat);
      expr_count++;
    end
    steady = 1'b0;
    tok_if.valid <= 1'b0;

    while (postfix_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d tokens (%0d acted on) in %0d random expressions plus the script.",
             tokens_sent, live_tokens, expr_count);
    $display("Checked %0d postfix beats, %0d of them error reports.",
             beats_checked, error_beats);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
